### hdl/bia_pkg.sv
// Shared types, constants and helpers for the bitmap ID allocator.
// No dependencies; used by bitmap_id_allocator.
`default_nettype none

package bia_pkg;

  localparam int IdCountDef = 1024;
  localparam int WordBits   = 32;
  localparam int BitIdxW    = 5;

  localparam int IdW     = 10;
  localparam int StatusW = 2;
  localparam int InUseW  = 11;

  typedef enum logic [StatusW-1:0] {
    ST_DONE         = 2'd0,
    ST_NONE_FREE    = 2'd1,
    ST_ALREADY_FREE = 2'd2
  } alloc_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_REL,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic           mode;
    logic [IdW-1:0] release_id;
  } req_t;

  typedef struct packed {
    logic [IdW-1:0]     granted_id;
    logic [StatusW-1:0] status;
    logic [InUseW-1:0]  in_use_count;
  } rsp_t;

  // Index of the lowest set bit; zero for an empty word.
  function automatic logic [BitIdxW-1:0] lowest_set(input logic [WordBits-1:0] w);
    logic [BitIdxW-1:0] idx;
    idx = '0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (w[b]) begin
        idx = BitIdxW'(b);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### hdl/bitmap_id_allocator.sv
// Bitmap ID allocator: next-fit scan over a word-wide free map held in memory.
// Depends on bia_pkg for payload structs, status codes and the bit search.
//
// Usage:
//   Input beats (in_valid/in_stall, in_data) carry one request: mode 0 asks
//   for an ID, mode 1 gives back release_id. Each request yields exactly one
//   result beat (out_valid/out_stall, out_data) with the granted ID, a status
//   and the number of IDs in use after the request.
//   Requests are handled one at a time; in_stall is high while one is busy.
//   An allocate reads one free-map word per cycle from the remembered word
//   onwards, k words in all (1 .. ID_COUNT/32). The single memory read port
//   sets that rate. A release reads its word once, in S_REL; a request
//   answered at once goes straight from S_IDLE to S_EMIT.
//   The result sits in an output register, so the next request is taken
//   while a result waits; a stalled result holds until out_stall drops.
//   After reset the block sweeps the free map to all ones, one word per
//   cycle, over all ID_COUNT/32 words, with in_stall high throughout.
`default_nettype none

module bitmap_id_allocator #(
  parameter int ID_COUNT = bia_pkg::IdCountDef
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  bia_pkg::req_t   in_data,
  output logic            out_valid,
  input  wire             out_stall,
  output bia_pkg::rsp_t   out_data
);

  localparam int WordCount = ID_COUNT / bia_pkg::WordBits;
  localparam int WW        = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam int FCW       = $clog2(ID_COUNT + 1);
  localparam logic [WW-1:0]  LastWord = WW'(WordCount - 1);
  localparam logic [FCW-1:0] IdCountW = FCW'(ID_COUNT);

  bia_pkg::state_t state_r, state_nxt;
  logic [WW-1:0]  addr_r, addr_nxt;
  logic [WW-1:0]  visit_r, visit_nxt;
  logic [WW-1:0]  scan_word_r, scan_word_nxt;
  logic [FCW-1:0] free_count_r, free_count_nxt;
  logic [bia_pkg::BitIdxW-1:0] rel_bit_r, rel_bit_nxt;
  logic [bia_pkg::IdW-1:0]     res_id_r, res_id_nxt;
  bia_pkg::alloc_status_t      res_status_r, res_status_nxt;
  logic           out_valid_r, out_valid_nxt;
  bia_pkg::rsp_t  out_data_r, out_data_nxt;

  logic [bia_pkg::WordBits-1:0] free_marks_r [WordCount];
  logic [bia_pkg::WordBits-1:0] rd_data_r;
  logic                         mem_we;
  logic [bia_pkg::WordBits-1:0] mem_wdata;
  logic [bia_pkg::BitIdxW-1:0]  hit_bit;

  assign in_stall  = (state_r != bia_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign hit_bit   = bia_pkg::lowest_set(rd_data_r);

  // Free map: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      free_marks_r[addr_r] <= mem_wdata;
    end
    rd_data_r <= free_marks_r[addr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bia_pkg::S_CLEAR;
      addr_r       <= '0;
      visit_r      <= '0;
      scan_word_r  <= '0;
      free_count_r <= IdCountW;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      visit_r      <= visit_nxt;
      scan_word_r  <= scan_word_nxt;
      free_count_r <= free_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rel_bit_r    <= rel_bit_nxt;
    res_id_r     <= res_id_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    visit_nxt      = visit_r;
    scan_word_nxt  = scan_word_r;
    free_count_nxt = free_count_r;
    rel_bit_nxt    = rel_bit_r;
    res_id_nxt     = res_id_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_wdata      = '1;

    unique case (state_r)
      bia_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        if (addr_r == LastWord) begin
          addr_nxt  = '0;
          state_nxt = bia_pkg::S_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      bia_pkg::S_IDLE: begin
        if (in_valid) begin
          res_id_nxt = '0;
          if (!in_data.mode) begin
            if (free_count_r == '0) begin
              res_status_nxt = bia_pkg::ST_NONE_FREE;
              state_nxt      = bia_pkg::S_EMIT;
            end else begin
              addr_nxt  = scan_word_r;
              visit_nxt = '0;
              state_nxt = bia_pkg::S_ALLOC;
            end
          end else begin
            if ({22'd0, in_data.release_id} >= 32'(ID_COUNT)) begin
              res_status_nxt = bia_pkg::ST_ALREADY_FREE;
              state_nxt      = bia_pkg::S_EMIT;
            end else begin
              addr_nxt    = WW'(in_data.release_id >> bia_pkg::BitIdxW);
              rel_bit_nxt = in_data.release_id[bia_pkg::BitIdxW-1:0];
              state_nxt   = bia_pkg::S_REL;
            end
          end
        end
      end

      bia_pkg::S_ALLOC: begin
        if (rd_data_r != '0) begin
          mem_we         = 1'b1;
          mem_wdata      = rd_data_r & ~(32'd1 << hit_bit);
          scan_word_nxt  = addr_r;
          free_count_nxt = free_count_r - 1'b1;
          res_id_nxt     = bia_pkg::IdW'({addr_r, hit_bit});
          res_status_nxt = bia_pkg::ST_DONE;
          state_nxt      = bia_pkg::S_EMIT;
        end else if (visit_r == LastWord) begin
          // full circle without a free bit: answer with ST_NONE_FREE
          res_status_nxt = bia_pkg::ST_NONE_FREE;
          state_nxt      = bia_pkg::S_EMIT;
        end else begin
          // advance; the read of the next word overlaps this check
          addr_nxt  = (addr_r == LastWord) ? '0 : addr_r + 1'b1;
          visit_nxt = visit_r + 1'b1;
        end
      end

      bia_pkg::S_REL: begin
        if (rd_data_r[rel_bit_r]) begin
          res_status_nxt = bia_pkg::ST_ALREADY_FREE;
        end else begin
          mem_we         = 1'b1;
          mem_wdata      = rd_data_r | (32'd1 << rel_bit_r);
          free_count_nxt = free_count_r + 1'b1;
          res_status_nxt = bia_pkg::ST_DONE;
        end
        state_nxt = bia_pkg::S_EMIT;
      end

      bia_pkg::S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.granted_id   = res_id_r;
          out_data_nxt.status       = res_status_r;
          out_data_nxt.in_use_count = bia_pkg::InUseW'(IdCountW - free_count_r);
          state_nxt                 = bia_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bia_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= IdCountW)
    else $error("free count above ID_COUNT");

  a_alloc_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bia_pkg::S_ALLOC && rd_data_r != '0)
      |=> (free_count_r == $past(free_count_r) - 1'b1) && (state_r == bia_pkg::S_EMIT))
    else $error("allocate hit did not take one ID");

  a_fail_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == bia_pkg::ST_NONE_FREE ||
                   out_data.status == bia_pkg::ST_ALREADY_FREE))
      |-> out_data.granted_id == '0)
    else $error("non-zero ID on a failed beat");
`endif

endmodule

`default_nettype wire
